[sv/spl_pkg.sv]
// ----------------------------------------------------------------------------
// spl_pkg
// Shared types, constants and lookup tables of the shift pressure lookup.
// ----------------------------------------------------------------------------
package spl_pkg;

  localparam int MAX_TORQUE_NM = 330;

  // Configuration register indexes
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPC_SCALE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MPC_SCALE = 2'd1;

  // Q2.14 scale limits (0.9 .. 1.1) and reset value (1.0)
  localparam logic [14:0] SCALE_LO  = 15'd14746;
  localparam logic [14:0] SCALE_HI  = 15'd18022;
  localparam logic [14:0] SCALE_ONE = 15'd16384;

  localparam logic [9:0] SHIFT_TIME_MS = 10'd500;
  localparam logic [9:0] PRESSURE_MAX  = 10'd1023;

  // Pressure maps, one row per gear change, points at load 0,10,...,100
  localparam logic [9:0] PRESS_MAP [0:7][0:10] = '{
    '{10'd530, 10'd520, 10'd510, 10'd500, 10'd490, 10'd480, 10'd470, 10'd460,
      10'd450, 10'd420, 10'd400},
    '{10'd500, 10'd490, 10'd480, 10'd470, 10'd460, 10'd450, 10'd440, 10'd430,
      10'd420, 10'd410, 10'd400},
    '{10'd500, 10'd485, 10'd475, 10'd462, 10'd452, 10'd336, 10'd431, 10'd420,
      10'd399, 10'd378, 10'd357},
    '{10'd490, 10'd470, 10'd450, 10'd430, 10'd410, 10'd390, 10'd370, 10'd350,
      10'd330, 10'd310, 10'd300},
    '{10'd540, 10'd530, 10'd520, 10'd510, 10'd490, 10'd480, 10'd470, 10'd460,
      10'd450, 10'd420, 10'd400},
    '{10'd415, 10'd415, 10'd411, 10'd410, 10'd405, 10'd400, 10'd390, 10'd380,
      10'd370, 10'd360, 10'd350},
    '{10'd470, 10'd462, 10'd430, 10'd420, 10'd410, 10'd400, 10'd380, 10'd360,
      10'd340, 10'd320, 10'd300},
    '{10'd430, 10'd431, 10'd395, 10'd385, 10'd385, 10'd370, 10'd360, 10'd360,
      10'd350, 10'd340, 10'd325}
  };

  // Fluid temperature multiplier, Q2.14, one point per 10 counts
  localparam logic [14:0] TEMP_MULT [0:16] = '{
    15'd13107, 15'd13107, 15'd13107, 15'd13107, 15'd13107,
    15'd13107, 15'd13435, 15'd13763, 15'd14090, 15'd14909,
    15'd15892, 15'd16384, 15'd16548, 15'd16548, 15'd16712, 15'd16712, 15'd16712
  };

  // Engine speed multiplier, Q2.14, one point per 1000 rpm
  localparam logic [14:0] RPM_MULT [0:8] = '{
    15'd17039, 15'd16712, 15'd16384, 15'd16056, 15'd15401,
    15'd14909, 15'd14418, 15'd13926, 15'd13435
  };

  // Loads and table positions after the first stage
  typedef struct packed {
    logic        ok;
    logic [2:0]  msel;
    logic [6:0]  sload;
    logic [6:0]  mload;
    logic [7:0]  t_val;
    logic [3:0]  t_i;
    logic        t_lo;
    logic        t_hi;
    logic [12:0] r_val;
    logic [2:0]  r_i;
    logic        r_hi;
  } spl_idx_t;

  // Interpolated map values and multipliers
  typedef struct packed {
    logic        ok;
    logic [9:0]  ms;
    logic [9:0]  mm;
    logic [14:0] tf;
    logic [14:0] rf;
  } spl_fac_t;

  // Result item
  typedef struct packed {
    logic [9:0] shift_pressure;
    logic [9:0] modulating_pressure;
    logic [9:0] shift_time_ms;
    logic       request_valid;
  } spl_res_t;

endpackage

[sv/spl_in_if.sv]
// ----------------------------------------------------------------------------
// spl_in_if
// Input channel: one sensor snapshot with a requested gear change.
// ----------------------------------------------------------------------------
interface spl_in_if;
  logic              valid;
  logic              ready;
  logic [3:0]        gear_change;
  logic [7:0]        pedal_position;
  logic signed [11:0] engine_torque;
  logic signed [8:0] fluid_temp_raw;
  logic [13:0]       engine_speed;

  modport source (
    output valid, gear_change, pedal_position, engine_torque, fluid_temp_raw,
    engine_speed,
    input  ready
  );
  modport sink (
    input  valid, gear_change, pedal_position, engine_torque, fluid_temp_raw,
    engine_speed,
    output ready
  );
endinterface

[sv/spl_out_if.sv]
// ----------------------------------------------------------------------------
// spl_out_if
// Result channel: shift and modulating pressure values, shift time and request valid.
// ----------------------------------------------------------------------------
interface spl_out_if;
  logic       valid;
  logic       ready;
  logic [9:0] shift_pressure;
  logic [9:0] modulating_pressure;
  logic [9:0] shift_time_ms;
  logic       request_valid;

  modport source (
    output valid, shift_pressure, modulating_pressure, shift_time_ms, request_valid,
    input  ready
  );
  modport sink (
    input  valid, shift_pressure, modulating_pressure, shift_time_ms, request_valid,
    output ready
  );
endinterface

[sv/spl_cfg_if.sv]
// ----------------------------------------------------------------------------
// spl_cfg_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
interface spl_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [spl_pkg::CFG_IDX_W-1:0] index;
  logic [14:0]                   data;

  modport source (
    output valid, index, data,
    input  ready
  );
  modport sink (
    input  valid, index, data,
    output ready
  );
endinterface

[sv/shift_pressure_lookup.sv]
// ----------------------------------------------------------------------------
// shift_pressure_lookup
// Gear change pressure lookup: map interpolation at shift and modulating
// load, scaled by temperature, engine speed and per-mode scale registers.
// ----------------------------------------------------------------------------
//  channel   role    payload                                          handshake
//  in_ch     sink    gear_change, pedal, torque, fluid temp, rpm      valid/ready
//  out_ch    source  shift/modulating pressure, shift time, valid     valid/ready
//  cfg_ch    sink    index, data (saturated to 0.9..1.1 in Q2.14)     valid/ready
//
//  One transfer per cycle while out_ch takes results; each result is registered
//  through index, two interpolation stages, divide and two multiply stages.
//  Reset clears all stage valid bits and sets both scales to 1.0.
//  While a result waits on out_ch, every stage holds and in_ch is not ready;
//  empty stages do not block, so the pipe keeps moving whenever out_ch takes.
//  Configuration writes are taken every cycle.
// ----------------------------------------------------------------------------
module shift_pressure_lookup #(
  parameter int MAX_TORQUE_NM = spl_pkg::MAX_TORQUE_NM
) (
  input  logic      clk,
  input  logic      rst_n,
  spl_in_if.sink    in_ch,
  spl_out_if.source out_ch,
  spl_cfg_if.sink   cfg_ch
);

  logic              pipe_en;
  logic              idx_valid;
  spl_pkg::spl_idx_t idx;
  logic              fac_valid;
  spl_pkg::spl_fac_t fac;
  logic              res_valid;
  spl_pkg::spl_res_t res;

  logic [14:0] spc_scale_r;
  logic [14:0] mpc_scale_r;
  logic [14:0] cfg_sat;

  // advance all stages unless the result register holds an untaken result
  assign pipe_en     = !res_valid || out_ch.ready;
  assign in_ch.ready = pipe_en;

  // ---- configuration registers
  assign cfg_ch.ready = 1'b1;

  always_comb begin
    if (cfg_ch.data < spl_pkg::SCALE_LO) begin
      cfg_sat = spl_pkg::SCALE_LO;
    end else if (cfg_ch.data > spl_pkg::SCALE_HI) begin
      cfg_sat = spl_pkg::SCALE_HI;
    end else begin
      cfg_sat = cfg_ch.data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      spc_scale_r <= spl_pkg::SCALE_ONE;
      mpc_scale_r <= spl_pkg::SCALE_ONE;
    end else if (cfg_ch.valid && cfg_ch.ready) begin
      case (cfg_ch.index)
        spl_pkg::CFG_SPC_SCALE: spc_scale_r <= cfg_sat;
        spl_pkg::CFG_MPC_SCALE: mpc_scale_r <= cfg_sat;
        default: ;  // drop writes to unknown registers
      endcase
    end
  end

  // ---- pipeline
  spl_index #(
    .MAX_TORQUE_NM(MAX_TORQUE_NM)
  ) u_index (
    .clk           (clk),
    .rst_n         (rst_n),
    .en            (pipe_en),
    .in_valid      (in_ch.valid),
    .gear_change   (in_ch.gear_change),
    .pedal_position(in_ch.pedal_position),
    .engine_torque (in_ch.engine_torque),
    .fluid_temp_raw(in_ch.fluid_temp_raw),
    .engine_speed  (in_ch.engine_speed),
    .idx_valid     (idx_valid),
    .idx           (idx)
  );

  spl_interp u_interp (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (pipe_en),
    .idx_valid(idx_valid),
    .idx      (idx),
    .fac_valid(fac_valid),
    .fac      (fac)
  );

  spl_scale u_scale (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (pipe_en),
    .fac_valid(fac_valid),
    .fac      (fac),
    .spc_scale(spc_scale_r),
    .mpc_scale(mpc_scale_r),
    .res_valid(res_valid),
    .res      (res)
  );

  assign out_ch.valid               = res_valid;
  assign out_ch.shift_pressure      = res.shift_pressure;
  assign out_ch.modulating_pressure = res.modulating_pressure;
  assign out_ch.shift_time_ms       = res.shift_time_ms;
  assign out_ch.request_valid       = res.request_valid;

  // ---- assertions
  a_scale_range: assert property (@(posedge clk) disable iff (!rst_n)
    spc_scale_r >= spl_pkg::SCALE_LO && spc_scale_r <= spl_pkg::SCALE_HI &&
    mpc_scale_r >= spl_pkg::SCALE_LO && mpc_scale_r <= spl_pkg::SCALE_HI)
    else $error("scale register outside 0.9..1.1");

  a_known_time: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.request_valid |-> out_ch.shift_time_ms == spl_pkg::SHIFT_TIME_MS)
    else $error("known request without nominal shift time");

  a_unknown_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.request_valid |->
      out_ch.shift_pressure == 10'd0 && out_ch.modulating_pressure == 10'd0 &&
      out_ch.shift_time_ms == 10'd0)
    else $error("unknown request with nonzero result");

  a_freeze: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid && !out_ch.ready |=> $stable(fac) && $stable(idx_valid))
    else $error("pipeline moved under output stall");

endmodule

[sv/spl_index.sv]
// ----------------------------------------------------------------------------
// spl_index
// First stage: shift and modulating loads, table positions of temperature
// and engine speed. Constant divisions use exact reciprocal multiplies.
// ----------------------------------------------------------------------------
module spl_index #(
  parameter int MAX_TORQUE_NM = spl_pkg::MAX_TORQUE_NM
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  logic               in_valid,
  input  logic [3:0]         gear_change,
  input  logic [7:0]         pedal_position,
  input  logic signed [11:0] engine_torque,
  input  logic signed [8:0]  fluid_temp_raw,
  input  logic [13:0]        engine_speed,
  output logic               idx_valid,
  output spl_pkg::spl_idx_t  idx
);

  // floor(x / MAX_TORQUE_NM) for x < 2^18 as (x * MT_RECIP) >> MT_K
  localparam int MT_K = 18 + $clog2(MAX_TORQUE_NM);
  localparam logic [19:0] MT_RECIP =
    20'(((64'd1 << MT_K) + 64'(MAX_TORQUE_NM) - 64'd1) / 64'(MAX_TORQUE_NM));

  logic              valid_r;
  spl_pkg::spl_idx_t idx_r;
  spl_pkg::spl_idx_t idx_nxt;

  logic [8:0]  ped_x2;
  logic [18:0] ped_prod;
  logic [6:0]  sload_q;
  logic [17:0] tq_x100;
  logic [37:0] tq_prod;
  logic [37:0] tq_q;
  logic [16:0] t_prod;
  logic [26:0] r_prod;

  always_comb begin
    // shift load = floor(2 * pedal / 5)
    ped_x2   = {pedal_position, 1'b0};
    ped_prod = ped_x2 * 19'd820;
    sload_q  = ped_prod[18:12];

    // modulating load from positive torque only
    tq_x100 = 18'(engine_torque[10:0]) * 18'd100;
    tq_prod = 38'(tq_x100) * 38'(MT_RECIP);
    tq_q    = tq_prod >> MT_K;

    t_prod = 17'(fluid_temp_raw[7:0]) * 17'd410;
    r_prod = 27'(engine_speed[12:0]) * 27'd8389;

    idx_nxt.ok    = (gear_change[3] == 1'b0);
    idx_nxt.msel  = gear_change[2:0];
    idx_nxt.sload = (sload_q > 7'd100) ? 7'd100 : sload_q;
    if (engine_torque[11]) begin
      idx_nxt.mload = 7'd0;
    end else if (tq_q > 38'd100) begin
      idx_nxt.mload = 7'd100;
    end else begin
      idx_nxt.mload = tq_q[6:0];
    end
    idx_nxt.t_val = fluid_temp_raw[7:0];
    idx_nxt.t_i   = t_prod[15:12];
    idx_nxt.t_lo  = fluid_temp_raw[8];
    idx_nxt.t_hi  = !fluid_temp_raw[8] && (fluid_temp_raw[7:0] >= 8'd160);
    idx_nxt.r_val = engine_speed[12:0];
    idx_nxt.r_i   = r_prod[25:23];
    idx_nxt.r_hi  = (engine_speed >= 14'd8000);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      idx_r <= idx_nxt;
    end
  end

  assign idx_valid = valid_r;
  assign idx       = idx_r;

endmodule

[sv/spl_interp.sv]
// ----------------------------------------------------------------------------
// spl_interp
// Three stages of linear interpolation: segment remainders and numerators,
// then exact divisions by 10 and 1000 through reciprocal multiplies.
// ----------------------------------------------------------------------------
module spl_interp (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              idx_valid,
  input  spl_pkg::spl_idx_t idx,
  output logic              fac_valid,
  output spl_pkg::spl_fac_t fac
);

  // a*step + (b-a)*r, non-negative for every table segment
  function automatic logic [24:0] lerp_num(input logic [14:0] a, input logic [14:0] b,
                                           input logic [9:0] r, input logic [9:0] step);
    logic signed [26:0] sa;
    logic signed [26:0] sb;
    logic signed [26:0] sr;
    logic signed [26:0] ss;
    logic signed [26:0] acc;
    sa  = $signed({12'd0, a});
    sb  = $signed({12'd0, b});
    sr  = $signed({17'd0, r});
    ss  = $signed({17'd0, step});
    acc = sa * ss + (sb - sa) * sr;
    return acc[24:0];
  endfunction

  // ---- stage B: load segments, temperature and rpm numerators
  logic        vb_r;
  logic        okb_r;
  logic [2:0]  mselb_r;
  logic [6:0]  sloadb_r;
  logic [6:0]  mloadb_r;
  logic [3:0]  lsib_r;
  logic [3:0]  lmib_r;
  logic [17:0] tnumb_r;
  logic [24:0] rnumb_r;

  logic [14:0] ls_prod;
  logic [14:0] lm_prod;
  logic [7:0]  t_rem;
  logic [12:0] r_rem;
  logic [4:0]  t_ia;
  logic [4:0]  t_ib;
  logic [3:0]  t_r;
  logic [3:0]  r_ia;
  logic [3:0]  r_ib;
  logic [9:0]  r_r;
  logic [24:0] tnum_full;
  logic [17:0] tnum_nxt;
  logic [24:0] rnum_nxt;

  always_comb begin
    ls_prod = 15'(idx.sload) * 15'd205;
    lm_prod = 15'(idx.mload) * 15'd205;
    t_rem   = idx.t_val - 8'({idx.t_i, 3'b000}) - 8'({idx.t_i, 1'b0});
    r_rem   = idx.r_val - 13'(idx.r_i) * 13'd1000;

    // clamped ends take one entry with zero remainder
    if (idx.t_lo) begin
      t_ia = 5'd0;
      t_ib = 5'd0;
      t_r  = 4'd0;
    end else if (idx.t_hi) begin
      t_ia = 5'd16;
      t_ib = 5'd16;
      t_r  = 4'd0;
    end else begin
      t_ia = {1'b0, idx.t_i};
      t_ib = {1'b0, idx.t_i} + 5'd1;
      t_r  = t_rem[3:0];
    end
    if (idx.r_hi) begin
      r_ia = 4'd8;
      r_ib = 4'd8;
      r_r  = 10'd0;
    end else begin
      r_ia = {1'b0, idx.r_i};
      r_ib = {1'b0, idx.r_i} + 4'd1;
      r_r  = r_rem[9:0];
    end
    tnum_full = lerp_num(spl_pkg::TEMP_MULT[t_ia], spl_pkg::TEMP_MULT[t_ib],
                         {6'd0, t_r}, 10'd10);
    tnum_nxt  = tnum_full[17:0];
    rnum_nxt  = lerp_num(spl_pkg::RPM_MULT[r_ia], spl_pkg::RPM_MULT[r_ib],
                         r_r, 10'd1000);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vb_r <= 1'b0;
    end else if (en) begin
      vb_r <= idx_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      okb_r    <= idx.ok;
      mselb_r  <= idx.msel;
      sloadb_r <= idx.sload;
      mloadb_r <= idx.mload;
      lsib_r   <= ls_prod[14:11];
      lmib_r   <= lm_prod[14:11];
      tnumb_r  <= tnum_nxt;
      rnumb_r  <= rnum_nxt;
    end
  end

  // ---- stage C: map numerators, temperature and rpm divisions
  logic        vc_r;
  logic        okc_r;
  logic [12:0] snumc_r;
  logic [12:0] mnumc_r;
  logic [14:0] tfc_r;
  logic [14:0] rfc_r;

  logic [6:0]  ls_rem;
  logic [6:0]  lm_rem;
  logic [3:0]  ls_ib;
  logic [3:0]  lm_ib;
  logic [24:0] snum_full;
  logic [24:0] mnum_full;
  logic [36:0] tf_prod;
  logic [50:0] rf_prod;

  always_comb begin
    ls_rem = sloadb_r - 7'(lsib_r) * 7'd10;
    lm_rem = mloadb_r - 7'(lmib_r) * 7'd10;
    // full load sits on the last point
    ls_ib  = (lsib_r == 4'd10) ? 4'd10 : lsib_r + 4'd1;
    lm_ib  = (lmib_r == 4'd10) ? 4'd10 : lmib_r + 4'd1;
    snum_full = lerp_num({5'd0, spl_pkg::PRESS_MAP[mselb_r][lsib_r]},
                         {5'd0, spl_pkg::PRESS_MAP[mselb_r][ls_ib]},
                         {6'd0, ls_rem[3:0]}, 10'd10);
    mnum_full = lerp_num({5'd0, spl_pkg::PRESS_MAP[mselb_r][lmib_r]},
                         {5'd0, spl_pkg::PRESS_MAP[mselb_r][lm_ib]},
                         {6'd0, lm_rem[3:0]}, 10'd10);
    tf_prod = 37'(tnumb_r) * 37'd419431;
    rf_prod = 51'(rnumb_r) * 51'd34359739;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vc_r <= 1'b0;
    end else if (en) begin
      vc_r <= vb_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      okc_r   <= okb_r;
      snumc_r <= snum_full[12:0];
      mnumc_r <= mnum_full[12:0];
      tfc_r   <= tf_prod[36:22];
      rfc_r   <= rf_prod[49:35];
    end
  end

  // ---- stage D: map values, divide numerators by 10
  logic              vd_r;
  spl_pkg::spl_fac_t facd_r;
  spl_pkg::spl_fac_t fac_nxt;
  logic [26:0]       ms_prod;
  logic [26:0]       mm_prod;

  always_comb begin
    ms_prod     = 27'(snumc_r) * 27'd13108;
    mm_prod     = 27'(mnumc_r) * 27'd13108;
    fac_nxt.ok  = okc_r;
    fac_nxt.ms  = ms_prod[26:17];
    fac_nxt.mm  = mm_prod[26:17];
    fac_nxt.tf  = tfc_r;
    fac_nxt.rf  = rfc_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vd_r <= 1'b0;
    end else if (en) begin
      vd_r <= vc_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      facd_r <= fac_nxt;
    end
  end

  assign fac_valid = vd_r;
  assign fac       = facd_r;

endmodule

[sv/spl_scale.sv]
// ----------------------------------------------------------------------------
// spl_scale
// Two multiply stages: map value times temperature multiplier beside rpm
// multiplier times mode scale, then the final product, truncate, saturate.
// ----------------------------------------------------------------------------
module spl_scale (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              fac_valid,
  input  spl_pkg::spl_fac_t fac,
  input  logic [14:0]       spc_scale,
  input  logic [14:0]       mpc_scale,
  output logic              res_valid,
  output spl_pkg::spl_res_t res
);

  // ---- stage E
  logic        ve_r;
  logic        oke_r;
  logic [24:0] ps_r;
  logic [24:0] pm_r;
  logic [29:0] rs_r;
  logic [29:0] rm_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ve_r <= 1'b0;
    end else if (en) begin
      ve_r <= fac_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      oke_r <= fac.ok;
      ps_r  <= 25'(fac.ms) * 25'(fac.tf);
      pm_r  <= 25'(fac.mm) * 25'(fac.tf);
      rs_r  <= 30'(fac.rf) * 30'(spc_scale);
      rm_r  <= 30'(fac.rf) * 30'(mpc_scale);
    end
  end

  // ---- stage F: result register
  logic              vf_r;
  spl_pkg::spl_res_t res_r;
  spl_pkg::spl_res_t res_nxt;
  logic [54:0]       full_s;
  logic [54:0]       full_m;
  logic [12:0]       q_s;
  logic [12:0]       q_m;

  always_comb begin
    full_s = 55'(ps_r) * 55'(rs_r);
    full_m = 55'(pm_r) * 55'(rm_r);
    q_s    = full_s[54:42];
    q_m    = full_m[54:42];
    if (oke_r) begin
      res_nxt.shift_pressure      = (q_s > 13'(spl_pkg::PRESSURE_MAX)) ?
                                    spl_pkg::PRESSURE_MAX : q_s[9:0];
      res_nxt.modulating_pressure = (q_m > 13'(spl_pkg::PRESSURE_MAX)) ?
                                    spl_pkg::PRESSURE_MAX : q_m[9:0];
      res_nxt.shift_time_ms       = spl_pkg::SHIFT_TIME_MS;
      res_nxt.request_valid       = 1'b1;
    end else begin
      // unknown request: zero all fields
      res_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vf_r <= 1'b0;
    end else if (en) begin
      vf_r <= ve_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res_r <= res_nxt;
    end
  end

  assign res_valid = vf_r;
  assign res       = res_r;

endmodule
